/* rtl/core/gql_pkg.sv */
`default_nettype none

package gql_pkg;

    // Field widths
    localparam int COORD_BITS = 12;
    localparam int CODE_BITS  = 8;
    localparam int CODE_SPAN  = 1 << CODE_BITS;
    localparam int POS_BITS   = 16;
    localparam int TEX_BITS   = 18;
    localparam int RECIP_BITS = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;
    localparam int PROD_BITS  = 39;

    localparam int GLYPH_ENTRIES_DEF = 256;

    localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [2:0]           VTX_LAST     = 3'd5;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_CHAR = 2'd1,
        REQ_END  = 2'd2
    } req_type_t;

    typedef enum logic {
        RES_VERTEX = 1'b0,
        RES_SHIFT  = 1'b1
    } result_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_HEIGHT   = 2'd0,
        CFG_RECIP_WIDTH  = 2'd1,
        CFG_RECIP_HEIGHT = 2'd2,
        CFG_CENTER_TEXT  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] xo;
        logic [COORD_BITS-1:0] yo;
        logic [COORD_BITS-1:0] adv;
    } glyph_t;

    localparam int GLYPH_W = $bits(glyph_t);

    typedef struct packed {
        logic [3:0]            pad;
        logic [COORD_BITS-1:0] glyph_x_advance;
        logic [COORD_BITS-1:0] glyph_y_offset;
        logic [COORD_BITS-1:0] glyph_x_offset;
        logic [COORD_BITS-1:0] glyph_height;
        logic [COORD_BITS-1:0] glyph_width;
        logic [COORD_BITS-1:0] glyph_y;
        logic [COORD_BITS-1:0] glyph_x;
        logic [CODE_BITS-1:0]  char_code;
    } in_item_t;

    typedef struct packed {
        logic [4:0]          pad;
        logic [15:0]         shift_y;
        logic [14:0]         shift_x;
        logic [TEX_BITS-1:0] tex_v;
        logic [TEX_BITS-1:0] tex_u;
        logic [POS_BITS-1:0] vertex_y;
        logic [POS_BITS-1:0] vertex_x;
    } out_item_t;

    function automatic logic signed [POS_BITS-1:0] sat16(input logic signed [17:0] v);
        logic signed [POS_BITS-1:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[POS_BITS-1:0];
        return r;
    endfunction

    // Q.24 product to Q1.16: round half up, then clamp to 18 bits
    function automatic logic [TEX_BITS-1:0] to_q16(input logic signed [PROD_BITS-1:0] p);
        logic signed [PROD_BITS:0] t;
        logic signed [31:0]        q;
        logic [TEX_BITS-1:0]       r;
        t = {p[PROD_BITS-1], p} + 40'sd128;
        q = t[PROD_BITS:8];
        if (q > 32'sd131071)
            r = 18'h1FFFF;
        else if (q < -32'sd131072)
            r = 18'h20000;
        else
            r = q[TEX_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/glyph_quad_layout.sv */
// Channel  | Dir | Signals                     | Contents
// ---------+-----+-----------------------------+------------------------------------------
// s_       | in  | tvalid tready tdata tuser   | glyph load, character or end-of-text item
// m_       | out | tvalid tready tdata tuser   | vertex or centering-shift result
//          |     | tlast                       | marks the final result of an item
// cfg_     | in  | we addr data                | tex_height, reciprocals, center_text
//
// A character item gives six result transactions, one per cycle while m_tready is high;
// an end item gives one shift result and a load none. For a result item m_tvalid rises
// after stage 1 (table read), stage 2 (positions and multiply), stage 3 (products held)
// and the output register (rounding). Loads write the table at once, so a following
// character sees the new glyph. Reset clears the glyph valid bits directly; no clearing
// pass. A stalled result channel holds the whole pipe; bubbles fill.
`default_nettype none

module glyph_quad_layout #(
    parameter int GLYPH_ENTRIES = gql_pkg::GLYPH_ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // char_code, glyph_x, glyph_y, glyph_width, glyph_height, glyph_x_offset,
    // glyph_y_offset, glyph_x_advance, zero pad
    input  wire logic [gql_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // vertex_x, vertex_y, tex_u, tex_v, shift_x, shift_y, zero pad
    output logic      [gql_pkg::OUT_DATA_W-1:0]  m_tdata,
    // result_kind
    output logic                                 m_tuser,
    // last_of_run
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [gql_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [gql_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import gql_pkg::*;

    localparam int TAB_DEPTH = (GLYPH_ENTRIES < CODE_SPAN) ? GLYPH_ENTRIES : CODE_SPAN;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    // Configuration
    logic [COORD_BITS-1:0] tex_height_reg;
    logic [RECIP_BITS-1:0] recip_w_reg;
    logic [RECIP_BITS-1:0] recip_h_reg;
    logic                  center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_height_reg <= 12'd256;
            recip_w_reg    <= 24'd65536;
            recip_h_reg    <= 24'd65536;
            center_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_TEX_HEIGHT:   tex_height_reg <= cfg_data[COORD_BITS-1:0];
                CFG_RECIP_WIDTH:  recip_w_reg    <= cfg_data[RECIP_BITS-1:0];
                CFG_RECIP_HEIGHT: recip_h_reg    <= cfg_data[RECIP_BITS-1:0];
                CFG_CENTER_TEXT:  center_reg     <= cfg_data[0];
                default:          center_reg     <= center_reg;
            endcase
        end
    end

    // Input decode and glyph table
    in_item_t          in_item;
    req_type_t         in_req;
    logic              accept;
    logic              in_range;
    logic [TAB_AW-1:0] tab_addr;
    logic              tab_we;
    glyph_t            tab_wdata;
    glyph_t            tab_rdata;
    logic [TAB_DEPTH-1:0] gvalid_reg;

    assign in_item  = in_item_t'(s_tdata);
    assign in_req   = req_type_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign in_range = (32'(in_item.char_code) < TAB_DEPTH);
    assign tab_addr = in_item.char_code[TAB_AW-1:0];
    assign tab_we   = accept && (in_req == REQ_LOAD) && in_range;

    always_comb
    begin
        tab_wdata.px  = in_item.glyph_x;
        tab_wdata.py  = in_item.glyph_y;
        tab_wdata.w   = in_item.glyph_width;
        tab_wdata.h   = in_item.glyph_height;
        tab_wdata.xo  = in_item.glyph_x_offset;
        tab_wdata.yo  = in_item.glyph_y_offset;
        tab_wdata.adv = in_item.glyph_x_advance;
    end

    gql_ram #(
        .WIDTH  (GLYPH_W),
        .DEPTH  (TAB_DEPTH),
        .ADDR_W (TAB_AW)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_addr),
        .wdata (tab_wdata),
        .re    (accept),
        .raddr (tab_addr),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvalid_reg <= '0;
        end
        else if (tab_we)
        begin
            gvalid_reg[tab_addr] <= 1'b1;
        end
    end

    // Stage 1: glyph lookup result, layout state
    logic                   s1_valid_reg;
    req_type_t              s1_req_reg;
    logic [CODE_BITS-1:0]   s1_code_reg;
    logic                   s1_hit_reg;
    logic                   s1_range_reg;
    logic [COORD_BITS-1:0]  s1_ld_h_reg;

    logic [COORD_BITS-1:0]  lh_reg;
    logic signed [15:0]     cx_reg;
    logic signed [15:0]     cy_reg;
    logic [15:0]            tw_reg;

    logic                   s1_res;
    logic                   s1_done;
    logic                   s1_ready;
    logic                   s2_ready;
    logic                   s3_ready;
    glyph_t                 s1_glyph;
    logic                   s1_nl;
    logic signed [15:0]     cy_nl;
    logic signed [15:0]     eff_cx;
    logic signed [15:0]     eff_cy;
    logic signed [15:0]     cx_adv;
    logic [16:0]            tw_sum;
    logic [15:0]            tw_next;
    logic [16:0]            sy_sum;
    logic [14:0]            s1_sx;
    logic [15:0]            s1_sy;

    assign s1_res   = (s1_req_reg == REQ_CHAR) || (s1_req_reg == REQ_END);
    assign s1_done  = s1_valid_reg && (!s1_res || s2_ready);
    assign s1_ready = !s1_valid_reg || s1_done;
    assign s_tready = s1_ready;

    always_comb
    begin
        s1_glyph = s1_hit_reg ? tab_rdata : '0;
        s1_nl    = (s1_code_reg == NEWLINE_CODE);
        cy_nl    = sat16({{2{cy_reg[15]}}, cy_reg} + {6'b0, lh_reg});
        eff_cx   = s1_nl ? 16'sd0 : cx_reg;
        eff_cy   = s1_nl ? cy_nl : cy_reg;
        cx_adv   = sat16({{2{eff_cx[15]}}, eff_cx} + {6'b0, s1_glyph.adv});
        tw_sum   = {1'b0, tw_reg} + {5'b0, s1_glyph.w};
        tw_next  = tw_sum[16] ? 16'hFFFF : tw_sum[15:0];
        // cursor_y never goes negative, so the sum is unsigned
        sy_sum   = {1'b0, cy_reg} + {5'b0, lh_reg};
        s1_sx    = center_reg ? tw_reg[15:1] : 15'd0;
        s1_sy    = center_reg ? sy_sum[16:1] : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lh_reg       <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            tw_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                case (s1_req_reg)
                    REQ_LOAD:
                    begin
                        if (s1_range_reg && (s1_ld_h_reg > lh_reg))
                        begin
                            lh_reg <= s1_ld_h_reg;
                        end
                    end
                    REQ_CHAR:
                    begin
                        cx_reg <= cx_adv;
                        cy_reg <= eff_cy;
                        tw_reg <= tw_next;
                    end
                    REQ_END:
                    begin
                        cx_reg <= '0;
                        cy_reg <= '0;
                        tw_reg <= '0;
                    end
                    default:
                    begin
                        lh_reg <= lh_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= in_req;
            s1_code_reg  <= in_item.char_code;
            s1_range_reg <= in_range;
            s1_hit_reg   <= in_range && gvalid_reg[tab_addr];
            s1_ld_h_reg  <= in_item.glyph_height;
        end
    end

    // Stage 2: positions and texture products
    logic               s2_valid_reg;
    result_kind_t       s2_kind_reg;
    logic signed [15:0] s2_cx_reg;
    logic signed [15:0] s2_cy_reg;
    glyph_t             s2_glyph_reg;
    logic [14:0]        s2_sx_reg;
    logic [15:0]        s2_sy_reg;
    logic               s2_load;

    assign s2_load  = s1_done && s1_res;
    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s3_ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_kind_reg  <= (s1_req_reg == REQ_END) ? RES_SHIFT : RES_VERTEX;
            s2_cx_reg    <= eff_cx;
            s2_cy_reg    <= eff_cy;
            s2_glyph_reg <= s1_glyph;
            s2_sx_reg    <= s1_sx;
            s2_sy_reg    <= s1_sy;
        end
    end

    logic signed [17:0]          x_base;
    logic signed [17:0]          y_base;
    logic signed [15:0]          s2_x0;
    logic signed [15:0]          s2_x1;
    logic signed [15:0]          s2_y0;
    logic signed [15:0]          s2_y1;
    logic signed [13:0]          cu0;
    logic signed [13:0]          cu1;
    logic signed [13:0]          cv0;
    logic signed [13:0]          cv1;
    logic signed [24:0]          rw;
    logic signed [24:0]          rh;
    logic signed [PROD_BITS-1:0] pu0;
    logic signed [PROD_BITS-1:0] pu1;
    logic signed [PROD_BITS-1:0] pv0;
    logic signed [PROD_BITS-1:0] pv1;

    always_comb
    begin
        x_base = {{2{s2_cx_reg[15]}}, s2_cx_reg}
               + {{6{s2_glyph_reg.xo[COORD_BITS-1]}}, s2_glyph_reg.xo};
        y_base = {{2{s2_cy_reg[15]}}, s2_cy_reg}
               + {{6{s2_glyph_reg.yo[COORD_BITS-1]}}, s2_glyph_reg.yo};
        s2_x0  = sat16(x_base);
        s2_x1  = sat16(x_base + {6'b0, s2_glyph_reg.w});
        s2_y0  = sat16(y_base);
        s2_y1  = sat16(y_base + {6'b0, s2_glyph_reg.h});
        // flip glyph y against the atlas height
        cu0    = {2'b0, s2_glyph_reg.px};
        cu1    = {2'b0, s2_glyph_reg.px} + {2'b0, s2_glyph_reg.w};
        cv0    = {2'b0, tex_height_reg} - {2'b0, s2_glyph_reg.py};
        cv1    = cv0 - {2'b0, s2_glyph_reg.h};
        rw     = {1'b0, recip_w_reg};
        rh     = {1'b0, recip_h_reg};
        pu0    = cu0 * rw;
        pu1    = cu1 * rw;
        pv0    = cv0 * rh;
        pv1    = cv1 * rh;
    end

    // Stage 3: products held for rounding
    logic                        s3_valid_reg;
    result_kind_t                s3_kind_reg;
    logic signed [15:0]          s3_x0_reg;
    logic signed [15:0]          s3_x1_reg;
    logic signed [15:0]          s3_y0_reg;
    logic signed [15:0]          s3_y1_reg;
    logic signed [PROD_BITS-1:0] s3_pu0_reg;
    logic signed [PROD_BITS-1:0] s3_pu1_reg;
    logic signed [PROD_BITS-1:0] s3_pv0_reg;
    logic signed [PROD_BITS-1:0] s3_pv1_reg;
    logic [14:0]                 s3_sx_reg;
    logic [15:0]                 s3_sy_reg;
    logic                        s3_load;
    logic                        ob_free;

    assign s3_load  = s2_valid_reg && s3_ready;
    assign s3_ready = !s3_valid_reg || ob_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_load)
        begin
            s3_valid_reg <= 1'b1;
        end
        else if (ob_free)
        begin
            s3_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_x0_reg   <= s2_x0;
            s3_x1_reg   <= s2_x1;
            s3_y0_reg   <= s2_y0;
            s3_y1_reg   <= s2_y1;
            s3_pu0_reg  <= pu0;
            s3_pu1_reg  <= pu1;
            s3_pv0_reg  <= pv0;
            s3_pv1_reg  <= pv1;
            s3_sx_reg   <= s2_sx_reg;
            s3_sy_reg   <= s2_sy_reg;
        end
    end

    // Output register: one quad or one shift result, walked out by vertex index
    logic                ob_valid_reg;
    result_kind_t        ob_kind_reg;
    logic [2:0]          ob_idx_reg;
    logic [15:0]         ob_x0_reg;
    logic [15:0]         ob_x1_reg;
    logic [15:0]         ob_y0_reg;
    logic [15:0]         ob_y1_reg;
    logic [TEX_BITS-1:0] ob_u0_reg;
    logic [TEX_BITS-1:0] ob_u1_reg;
    logic [TEX_BITS-1:0] ob_v0_reg;
    logic [TEX_BITS-1:0] ob_v1_reg;
    logic [14:0]         ob_sx_reg;
    logic [15:0]         ob_sy_reg;
    logic                ob_last;
    logic                ob_load;
    logic                out_xfer;

    assign ob_last  = (ob_kind_reg == RES_SHIFT) || (ob_idx_reg == VTX_LAST);
    assign out_xfer = ob_valid_reg && m_tready;
    assign ob_free  = !ob_valid_reg || (m_tready && ob_last);
    assign ob_load  = s3_valid_reg && ob_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            ob_idx_reg   <= '0;
        end
        else if (ob_load)
        begin
            ob_valid_reg <= 1'b1;
            ob_idx_reg   <= '0;
        end
        else if (out_xfer)
        begin
            if (ob_last)
            begin
                ob_valid_reg <= 1'b0;
            end
            else
            begin
                ob_idx_reg <= ob_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_load)
        begin
            ob_kind_reg <= s3_kind_reg;
            ob_x0_reg   <= s3_x0_reg;
            ob_x1_reg   <= s3_x1_reg;
            ob_y0_reg   <= s3_y0_reg;
            ob_y1_reg   <= s3_y1_reg;
            ob_u0_reg   <= to_q16(s3_pu0_reg);
            ob_u1_reg   <= to_q16(s3_pu1_reg);
            ob_v0_reg   <= to_q16(s3_pv0_reg);
            ob_v1_reg   <= to_q16(s3_pv1_reg);
            ob_sx_reg   <= s3_sx_reg;
            ob_sy_reg   <= s3_sy_reg;
        end
    end

    // Vertex order: (x0,y0) (x0,y1) (x1,y1) (x0,y0) (x1,y1) (x1,y0)
    logic      use_x1;
    logic      use_y1;
    out_item_t out_item;

    always_comb
    begin
        use_x1   = ob_idx_reg inside {3'd2, 3'd4, 3'd5};
        use_y1   = ob_idx_reg inside {3'd1, 3'd2, 3'd4};
        out_item = '0;
        case (ob_kind_reg)
            RES_VERTEX:
            begin
                out_item.vertex_x = use_x1 ? ob_x1_reg : ob_x0_reg;
                out_item.vertex_y = use_y1 ? ob_y1_reg : ob_y0_reg;
                out_item.tex_u    = use_x1 ? ob_u1_reg : ob_u0_reg;
                out_item.tex_v    = use_y1 ? ob_v1_reg : ob_v0_reg;
            end
            RES_SHIFT:
            begin
                out_item.shift_x = ob_sx_reg;
                out_item.shift_y = ob_sy_reg;
            end
            default:
            begin
                out_item = '0;
            end
        endcase
    end

    assign m_tvalid = ob_valid_reg;
    assign m_tdata  = out_item;
    assign m_tuser  = ob_kind_reg;
    assign m_tlast  = ob_last;

endmodule

`default_nettype wire

/* rtl/core/gql_ram.sv */
`default_nettype none

module gql_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
